@@ rtl/core/ldg_pkg.sv @@
// Shared constants, types and tables for the load-based DVFS step governor.
package ldg_pkg;

  localparam int FREQ_BITS_DEF = 24;
  localparam int FREQ_PORT_W   = 24;
  localparam int PCT_W         = 7;
  localparam int INTERVAL_W    = 8;
  localparam int NEXT_INT_W    = 9;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 48;
  localparam int CFG_INDEX_W   = 3;

  localparam int PCT_MAX           = 100;
  localparam int ALPHA_FLOOR       = 30;
  localparam int ALPHA_DIV         = 3;
  localparam int LOW_BATT_PCT      = 20;
  localparam int MID_BATT_PCT      = 50;
  localparam int BATT_UNKNOWN      = 50;
  localparam int AC_BIAS           = 1;
  localparam int LOW_BATT_BIAS     = 10;
  localparam int MID_BATT_BIAS     = 5;
  localparam int BIAS_CAP          = 10;
  localparam int IDLE_LOAD         = 5;
  localparam int LATCH_PERIOD      = 5;
  localparam int FALLBACK_STEP_PCT = 5;

  // Divide by 100 as a multiply and shift. The wide pair is exact for any
  // 32-bit dividend, the narrow pair for dividends up to 10000.
  localparam logic [31:0] DIV100_MUL     = 32'h51EB851F;
  localparam int          DIV100_SHIFT   = 37;
  localparam logic [12:0] DIV100_MUL_S   = 13'd5243;
  localparam int          DIV100_SHIFT_S = 19;

  // Cycles from a configuration change until the step size is valid again.
  localparam int STEP_SETTLE = 3;

  localparam int UP_THR_RST    = 70;
  localparam int DOWN_THR_RST  = 10;
  localparam int STEP_PCT_RST  = 5;
  localparam int DOWN_WAIT_RST = 2;
  localparam int BASE_BIAS_RST = 0;
  localparam int INTERVAL_RST  = 1;
  localparam int MAX_FREQ_RST  = 3000000;
  localparam int MIN_FREQ_RST  = 800000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UP_THR    = 3'd0,
    REG_DOWN_THR  = 3'd1,
    REG_STEP_PCT  = 3'd2,
    REG_DOWN_WAIT = 3'd3,
    REG_BASE_BIAS = 3'd4,
    REG_INTERVAL  = 3'd5,
    REG_MAX_FREQ  = 3'd6,
    REG_MIN_FREQ  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [PCT_W-1:0]      up_thr;
    logic [PCT_W-1:0]      down_thr;
    logic [2:0]            down_wait;
    logic [3:0]            base_bias;
    logic [INTERVAL_W-1:0] interval;
  } gov_cfg_t;

  // Smoothing weight indexed by (load + 100 - previous load), floored at 30.
  typedef logic [PCT_W-1:0] alpha_tbl_t [256];

  function automatic alpha_tbl_t make_alpha_tbl();
    alpha_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = (i / ALPHA_DIV < ALPHA_FLOOR) ? PCT_W'(ALPHA_FLOOR) : PCT_W'(i / ALPHA_DIV);
    end
    return tbl;
  endfunction

  localparam alpha_tbl_t ALPHA_TBL = make_alpha_tbl();

endpackage

@@ rtl/core/ldg_cfg.sv @@
// Configuration registers and the step-size pipeline of the governor.
module ldg_cfg
  import ldg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FREQ_BITS-1:0]   cfg_data,
  output gov_cfg_t               gcfg,
  output logic [FREQ_BITS-1:0]   freq_hi,
  output logic [FREQ_BITS-1:0]   freq_lo,
  output logic [FREQ_BITS-1:0]   step_freq,
  output logic                   step_ok
);

  localparam int SW = $clog2(STEP_SETTLE + 1);

  logic [4:0]           step_pct;
  logic [SW-1:0]        settle;
  logic [FREQ_BITS-1:0] hi_div;
  logic [FREQ_BITS-1:0] hi_quo;
  logic [6:0]           hi_rem;

  logic [63:0]          recip_prod;
  logic [FREQ_BITS-1:0] rem_full;
  logic [11:0]          pct_rem;
  logic [11:0]          fb_rem;
  logic [23:0]          pct_frac;
  logic [23:0]          fb_frac;
  logic [FREQ_BITS-1:0] pct_step;
  logic [FREQ_BITS-1:0] fb_step;
  logic [FREQ_BITS-1:0] step_pick;

  assign cfg_ready = 1'b1;
  assign step_ok   = (settle == '0);

  // The step is pct * hi / 100, split as pct * (hi / 100) + pct * (hi % 100) / 100.
  always_comb begin
    recip_prod = 64'(freq_hi) * 64'(DIV100_MUL);
    rem_full   = freq_hi - hi_div * FREQ_BITS'(PCT_MAX);
    pct_rem    = 12'(step_pct) * 12'(hi_rem);
    fb_rem     = 12'(FALLBACK_STEP_PCT) * 12'(hi_rem);
    pct_frac   = 24'(pct_rem) * 24'(DIV100_MUL_S);
    fb_frac    = 24'(fb_rem) * 24'(DIV100_MUL_S);
    pct_step   = FREQ_BITS'(step_pct) * hi_quo
               + FREQ_BITS'(pct_frac >> DIV100_SHIFT_S);
    fb_step    = FREQ_BITS'(FALLBACK_STEP_PCT) * hi_quo
               + FREQ_BITS'(fb_frac >> DIV100_SHIFT_S);
    // A step that rounds to zero falls back to 5 percent, then to one kHz.
    if (pct_step != '0) begin
      step_pick = pct_step;
    end else if (fb_step != '0) begin
      step_pick = fb_step;
    end else begin
      step_pick = FREQ_BITS'(1);
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle         <= SW'(STEP_SETTLE);
      gcfg.up_thr    <= PCT_W'(UP_THR_RST);
      gcfg.down_thr  <= PCT_W'(DOWN_THR_RST);
      step_pct       <= 5'(STEP_PCT_RST);
      gcfg.down_wait <= 3'(DOWN_WAIT_RST);
      gcfg.base_bias <= 4'(BASE_BIAS_RST);
      gcfg.interval  <= INTERVAL_W'(INTERVAL_RST);
      freq_hi        <= FREQ_BITS'(MAX_FREQ_RST);
      freq_lo        <= FREQ_BITS'(MIN_FREQ_RST);
    end else begin
      // A write restarts the step computation with the new values.
      if (cfg_valid) begin
        settle <= SW'(STEP_SETTLE);
        unique case (cfg_reg_t'(cfg_index))
          REG_UP_THR:    gcfg.up_thr    <= cfg_data[PCT_W-1:0];
          REG_DOWN_THR:  gcfg.down_thr  <= cfg_data[PCT_W-1:0];
          REG_STEP_PCT:  step_pct       <= cfg_data[4:0];
          REG_DOWN_WAIT: gcfg.down_wait <= cfg_data[2:0];
          REG_BASE_BIAS: gcfg.base_bias <= cfg_data[3:0];
          REG_INTERVAL:  gcfg.interval  <= cfg_data[INTERVAL_W-1:0];
          REG_MAX_FREQ:  freq_hi        <= cfg_data;
          REG_MIN_FREQ:  freq_lo        <= cfg_data;
          default:       ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - SW'(1);
      end
    end
  end

  // Three-stage step pipeline: quotient, then remainder, then the step itself.
  always_ff @(posedge clk) begin
    hi_div    <= FREQ_BITS'(recip_prod >> DIV100_SHIFT);
    hi_quo    <= hi_div;
    hi_rem    <= rem_full[6:0];
    step_freq <= step_pick;
  end

endmodule

@@ rtl/core/ldg_core.sv @@
// Governor state and the single-pass decision logic for one sampling tick.
module ldg_core
  import ldg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [PCT_W-1:0]      load_pct,
  input  logic [FREQ_BITS-1:0]  cur_freq,
  input  logic                  ac_online,
  input  logic [PCT_W-1:0]      battery_pct,
  input  gov_cfg_t              gcfg,
  input  logic [FREQ_BITS-1:0]  freq_hi,
  input  logic [FREQ_BITS-1:0]  freq_lo,
  input  logic [FREQ_BITS-1:0]  step_freq,
  output logic [FREQ_BITS-1:0]  target_freq,
  output dir_t                  direction,
  output logic [NEXT_INT_W-1:0] next_interval,
  output logic [PCT_W-1:0]      filtered_load
);

  logic [FREQ_BITS-1:0] freq_req;
  logic [PCT_W-1:0]     previous_load;
  logic [2:0]           low_period_count;
  logic [PCT_W-1:0]     load_avg;
  logic                 latched_ac;
  logic [PCT_W-1:0]     latched_battery;

  logic [PCT_W-1:0]      load;
  logic                  refresh;
  logic                  on_ac;
  logic [PCT_W-1:0]      battery;
  logic [INTERVAL_W-1:0] interval;
  logic [7:0]            alpha_idx;
  logic [PCT_W-1:0]      alpha;
  logic [13:0]           mix;
  logic [26:0]           mix_scaled;
  logic [PCT_W-1:0]      smooth;
  logic [FREQ_BITS-1:0]  req;
  logic [FREQ_BITS:0]    req_sum;
  logic [3:0]            base;
  logic [4:0]            bias;
  logic [7:0]            up_raw;
  logic [7:0]            down_raw;
  logic [7:0]            up_eff;
  logic [7:0]            down_eff;
  logic [3:0]            cnt_inc;
  logic [FREQ_BITS-1:0]  req_next;
  logic [2:0]            count_next;
  dir_t                  dir_next;

  always_comb begin
    load    = (load_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : load_pct;
    refresh = (low_period_count == 3'd0) || (low_period_count == 3'(LATCH_PERIOD));
    on_ac   = refresh ? ac_online : latched_ac;
    if (!refresh) begin
      battery = latched_battery;
    end else if (ac_online) begin
      battery = PCT_W'(BATT_UNKNOWN);
    end else begin
      battery = battery_pct;
    end

    interval = (gcfg.interval == '0) ? INTERVAL_W'(1) : gcfg.interval;
    if (load < PCT_W'(IDLE_LOAD) && load_avg < PCT_W'(IDLE_LOAD)) begin
      next_interval = {interval, 1'b0};
    end else begin
      next_interval = {1'b0, interval};
    end

    // Adaptive moving average, then a divide by 100 as a reciprocal multiply.
    alpha_idx  = 8'(load) + 8'(PCT_MAX) - 8'(previous_load);
    alpha      = ALPHA_TBL[alpha_idx];
    mix        = 14'(alpha) * 14'(load)
               + 14'(PCT_W'(PCT_MAX) - alpha) * 14'(load_avg);
    mix_scaled = 27'(mix) * 27'(DIV100_MUL_S);
    smooth     = PCT_W'(mix_scaled >> DIV100_SHIFT_S);

    // A request outside the policy window is stale; restart from the present frequency.
    req = (freq_req > freq_hi || freq_req < freq_lo) ? cur_freq : freq_req;
    req_sum = {1'b0, req} + {1'b0, step_freq};

    base = (gcfg.base_bias > 4'(BIAS_CAP)) ? 4'(BIAS_CAP) : gcfg.base_bias;
    if (on_ac) begin
      bias = 5'(base) + 5'(AC_BIAS);
    end else if (battery <= PCT_W'(LOW_BATT_PCT)) begin
      bias = 5'(base) + 5'(LOW_BATT_BIAS);
    end else if (battery <= PCT_W'(MID_BATT_PCT)) begin
      bias = 5'(base) + 5'(MID_BATT_BIAS);
    end else begin
      bias = 5'(base);
    end

    up_raw   = 8'(gcfg.up_thr) + 8'(bias);
    down_raw = 8'(gcfg.down_thr) + 8'(bias);
    if (up_raw > 8'(PCT_MAX)) begin
      up_eff = 8'(PCT_MAX);
    end else if (up_raw == '0) begin
      up_eff = 8'd1;
    end else begin
      up_eff = up_raw;
    end
    down_eff = (down_raw >= up_eff) ? up_eff - 8'd1 : down_raw;

    cnt_inc    = {1'b0, low_period_count} + 4'd1;
    req_next   = req;
    dir_next   = DIR_NONE;
    count_next = '0;
    if (8'(smooth) > up_eff) begin
      if (req != freq_hi) begin
        req_next = (req_sum > {1'b0, freq_hi}) ? freq_hi : req_sum[FREQ_BITS-1:0];
        dir_next = DIR_UP;
      end
    end else if (8'(load) < down_eff) begin
      if (cnt_inc >= {1'b0, gcfg.down_wait}) begin
        if (req != freq_lo) begin
          req_next = (req > step_freq) ? req - step_freq : freq_lo;
          dir_next = DIR_DOWN;
        end
      end else begin
        count_next = cnt_inc[2:0];
      end
    end

    target_freq   = req_next;
    direction     = dir_next;
    filtered_load = smooth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_req         <= '0;
      previous_load    <= '0;
      low_period_count <= '0;
      load_avg         <= '0;
      latched_ac       <= 1'b0;
      latched_battery  <= PCT_W'(BATT_UNKNOWN);
    end else if (advance) begin
      freq_req         <= req_next;
      previous_load    <= load;
      low_period_count <= count_next;
      load_avg         <= smooth;
      if (refresh) begin
        latched_ac      <= on_ac;
        latched_battery <= battery;
      end
    end
  end

endmodule

@@ rtl/core/load_based_dvfs_step_governor.sv @@
// Top level of the load-based DVFS step governor: stream ports and the two pipeline registers.
//
// Usage: each request on the slave stream is one sampling tick (load, present
// frequency, power status). The block answers every tick with exactly one result
// on the master stream: the new requested frequency, the step direction, the
// next sampling interval and the smoothed load.
// Registers are written on the cfg channel (index 0..7, always ready); write
// them only while no tick is in flight.
// Flow: an accepted tick waits in the input register until the result register is free
// or being read, then moves into it. One tick per cycle is sustained while m_tready
// stays high; the input register, the decision logic and the result register form
// a single pass whose state is updated as each tick moves into the result register.
// Reset: state clears, registers take their reset values, and the step size is
// then derived by a three-stage multiply pipeline; s_tready stays low until that
// pipeline has settled, after reset and after every configuration write.
// Backpressure: when m_tready is low the result holds, one more tick may wait
// in the input register, and s_tready then drops until the result is taken.
module load_based_dvfs_step_governor
  import ldg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [6:0] load_pct, [30:7] current_freq_khz, [31] ac_online, [38:32] battery_pct
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [23:0] target_freq_khz, [25:24] direction, [34:26] next_interval, [41:35] filtered_load
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FREQ_BITS-1:0]   cfg_data
);

  localparam int WIDE = (FREQ_BITS > FREQ_PORT_W) ? FREQ_BITS : FREQ_PORT_W;

  logic                   in_valid;
  logic [PCT_W-1:0]       in_load;
  logic [FREQ_PORT_W-1:0] in_cur;
  logic                   in_ac;
  logic [PCT_W-1:0]       in_batt;
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  gov_cfg_t              gcfg;
  logic [FREQ_BITS-1:0]  freq_hi;
  logic [FREQ_BITS-1:0]  freq_lo;
  logic [FREQ_BITS-1:0]  step_freq;
  logic                  step_ok;
  logic                  advance;
  logic [WIDE-1:0]       cur_wide;
  logic [WIDE-1:0]       tgt_wide;
  logic [FREQ_BITS-1:0]  target_freq;
  dir_t                  direction;
  logic [NEXT_INT_W-1:0] next_interval;
  logic [PCT_W-1:0]      filtered_load;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = step_ok && (!in_valid || advance);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign cur_wide = WIDE'(in_cur);
  assign tgt_wide = WIDE'(target_freq);

  ldg_cfg #(
    .FREQ_BITS (FREQ_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gcfg      (gcfg),
    .freq_hi   (freq_hi),
    .freq_lo   (freq_lo),
    .step_freq (step_freq),
    .step_ok   (step_ok)
  );

  ldg_core #(
    .FREQ_BITS (FREQ_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .load_pct      (in_load),
    .cur_freq      (cur_wide[FREQ_BITS-1:0]),
    .ac_online     (in_ac),
    .battery_pct   (in_batt),
    .gcfg          (gcfg),
    .freq_hi       (freq_hi),
    .freq_lo       (freq_lo),
    .step_freq     (step_freq),
    .target_freq   (target_freq),
    .direction     (direction),
    .next_interval (next_interval),
    .filtered_load (filtered_load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_load <= s_tdata[6:0];
      in_cur  <= s_tdata[30:7];
      in_ac   <= s_tdata[31];
      in_batt <= s_tdata[38:32];
    end
    if (advance) begin
      out_data <= {6'd0, filtered_load, next_interval, 2'(direction),
                   tgt_wide[FREQ_PORT_W-1:0]};
    end
  end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the load-based DVFS step governor.
`timescale 1ns / 1ps

module tb;
  import ldg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_TICKS   = 170;

  // One sampling tick as packed on s_tdata.
  typedef struct packed {
    logic        pad;
    logic [6:0]  battery;
    logic        ac;
    logic [23:0] cur;
    logic [6:0]  load;
  } tick_t;

  // One governor answer as packed on m_tdata.
  typedef struct packed {
    logic [5:0]  pad;
    logic [6:0]  filt;
    logic [8:0]  next_int;
    dir_t        dir;
    logic [23:0] freq;
  } gov_res_t;

  typedef struct {
    logic [6:0]  up;
    logic [6:0]  down;
    logic [4:0]  step;
    logic [2:0]  down_wait;
    logic [3:0]  bias;
    logic [7:0]  ival;
    logic [23:0] fmax;
    logic [23:0] fmin;
  } gov_setup_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_TDATA_W-1:0]    s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [FREQ_BITS_DEF-1:0] cfg_data = '0;

  load_based_dvfs_step_governor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Governor settings and state as the block should hold them.
  gov_setup_t  setup;
  logic [23:0] gov_freq;
  logic [6:0]  last_load;
  logic [2:0]  low_cnt;
  logic [6:0]  avg_load;
  logic        lat_ac;
  logic [6:0]  lat_batt;

  tick_t    pending_ticks[$];
  gov_res_t due_results[$];
  int       ticks_sent = 0;
  int       results_seen = 0;
  int       errors = 0;
  int       cycles = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  int plan [8][8] = '{
    '{60,  20, 10, 3, 2,  10,  3000000,  800000},
    '{100, 0,  25, 1, 10, 255, 16777215, 0},
    '{0,   99, 5,  5, 0,  1,   1000000,  999000},
    '{127, 127, 31, 7, 15, 0,  0,        0},
    '{40,  35, 0,  0, 1,  128, 2000,     5000},
    '{75,  15, 20, 2, 4,  30,  16777215, 16777000},
    '{90,  5,  17, 4, 10, 200, 4000000,  100},
    '{50,  49, 12, 1, 0,  2,   5000000,  300000}
  };

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic reset_model();
    setup.up        = 7'd70;
    setup.down      = 7'd10;
    setup.step      = 5'd5;
    setup.down_wait = 3'd2;
    setup.bias      = 4'd0;
    setup.ival      = 8'd1;
    setup.fmax      = 24'd3000000;
    setup.fmin      = 24'd800000;
    gov_freq  = '0;
    last_load = '0;
    low_cnt   = '0;
    avg_load  = '0;
    lat_ac    = 1'b0;
    lat_batt  = 7'd50;
  endtask

  // Runs one tick through the governor and advances its state.
  function automatic gov_res_t govern_tick(tick_t t);
    longint ld, pl, avg, cur, ival, alpha, smooth, req;
    longint fmax, fmin, step, bias, batt, up, dn;
    logic on_ac, fresh;
    int cnt;
    gov_res_t r;
    r = '0;
    ld = longint'(t.load);
    if (ld > 100) ld = 100;
    pl = longint'(last_load);
    avg = longint'(avg_load);
    cur = longint'(t.cur);
    fmax = longint'(setup.fmax);
    fmin = longint'(setup.fmin);
    // Power status is only sampled when the low-period count is a multiple of five.
    fresh = (low_cnt % 3'd5) == 3'd0;
    on_ac = lat_ac;
    batt = longint'(lat_batt);
    if (fresh) begin
      on_ac = t.ac;
      batt = t.ac ? 50 : longint'(t.battery);
    end
    ival = (setup.ival == 8'd0) ? 1 : longint'(setup.ival);
    r.next_int = 9'((ld < 5 && avg < 5) ? ival * 2 : ival);
    alpha = (ld + 100 - pl) / 3;
    if (alpha < 30) alpha = 30;
    smooth = (alpha * ld + (100 - alpha) * avg) / 100;
    req = longint'(gov_freq);
    if (req > fmax || req < fmin) req = cur;
    step = (longint'(setup.step) * fmax) / 100;
    if (step == 0) step = (5 * fmax) / 100;
    if (step == 0) step = 1;
    bias = (setup.bias > 4'd10) ? 10 : longint'(setup.bias);
    if (on_ac) bias += 1;
    else if (batt <= 20) bias += 10;
    else if (batt <= 50) bias += 5;
    up = bias + longint'(setup.up);
    dn = bias + longint'(setup.down);
    if (up > 100) up = 100;
    if (up < 1) up = 1;
    if (dn >= up) dn = up - 1;
    r.dir = DIR_NONE;
    cnt = int'(low_cnt);
    if (smooth > up) begin
      if (req != fmax) begin
        req += step;
        if (req > fmax) req = fmax;
        r.dir = DIR_UP;
      end
      cnt = 0;
    end else if (ld < dn) begin
      cnt++;
      if (cnt >= int'(setup.down_wait)) begin
        if (req != fmin) begin
          req = (req > step) ? req - step : fmin;
          r.dir = DIR_DOWN;
        end
        cnt = 0;
      end
    end else begin
      cnt = 0;
    end
    if (fresh) begin
      lat_ac = on_ac;
      lat_batt = batt[6:0];
    end
    last_load = ld[6:0];
    gov_freq  = req[23:0];
    low_cnt   = cnt[2:0];
    avg_load  = smooth[6:0];
    r.freq = req[23:0];
    r.filt = smooth[6:0];
    return r;
  endfunction

  task automatic put(logic [6:0] ld, logic [23:0] cf, logic ac, logic [6:0] bt);
    tick_t t;
    t = '{pad: 1'b0, battery: bt, ac: ac, cur: cf, load: ld};
    pending_ticks.push_back(t);
    ticks_sent++;
  endtask

  // Runs of high, low and medium load with noise mixed in, so that step-ups,
  // step-downs after the wait count and the power latch all get exercised.
  task automatic add_random(int n);
    int kind, len;
    logic [6:0] ld, bt;
    logic [23:0] cf;
    while (n > 0) begin
      kind = int'($urandom_range(9));
      len = int'($urandom_range(12, 2));
      for (int i = 0; i < len && n > 0; i++) begin
        case (kind)
          0, 1, 2, 3: ld = 7'($urandom_range(100, 55));
          4, 5, 6:    ld = 7'($urandom_range(12));
          7:          ld = 7'($urandom_range(100));
          default:    ld = 7'($urandom_range(127));
        endcase
        case ($urandom_range(9))
          0:       cf = '0;
          1:       cf = '1;
          2, 3:    cf = 24'($urandom);
          default: cf = (setup.fmin <= setup.fmax) ?
                        24'($urandom_range(setup.fmax, setup.fmin)) : 24'($urandom);
        endcase
        case ($urandom_range(7))
          0, 1:    bt = 7'($urandom_range(20));
          2, 3:    bt = 7'($urandom_range(50, 21));
          4, 5:    bt = 7'($urandom_range(100, 51));
          6:       bt = 7'd50;
          default: bt = 7'($urandom_range(127, 101));
        endcase
        put(ld, cf, 1'($urandom_range(1)), bt);
        n--;
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_UP_THR:    setup.up = val[6:0];
      REG_DOWN_THR:  setup.down = val[6:0];
      REG_STEP_PCT:  setup.step = val[4:0];
      REG_DOWN_WAIT: setup.down_wait = val[2:0];
      REG_BASE_BIAS: setup.bias = val[3:0];
      REG_INTERVAL:  setup.ival = val[7:0];
      REG_MAX_FREQ:  setup.fmax = val;
      REG_MIN_FREQ:  setup.fmin = val;
    endcase
  endtask

  task automatic drain();
    while (results_seen < ticks_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request side: present queued ticks, predict each one as it is taken.
  always @(posedge clk) begin : drive
    logic go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) due_results.push_back(govern_tick(tick_t'(s_tdata)));
      if (!s_tvalid || s_tready) begin
        go = (pending_ticks.size() != 0) && ($urandom_range(99) >= gap_pct);
        if (go) s_tdata <= pending_ticks.pop_front();
        s_tvalid <= go;
      end
    end
  end

  // Result side: check each taken result against the oldest expectation.
  always @(posedge clk) begin : watch
    gov_res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (due_results.size() == 0) begin
          report($sformatf("result with no tick outstanding, target %0d", got.freq));
        end else begin
          want = due_results.pop_front();
          if (got.freq !== want.freq)
            report($sformatf("target_freq_khz got %0d expected %0d", got.freq, want.freq));
          if (got.dir !== want.dir)
            report($sformatf("direction got %0d expected %0d", got.dir, want.dir));
          if (got.next_int !== want.next_int)
            report($sformatf("next_interval got %0d expected %0d",
                             got.next_int, want.next_int));
          if (got.filt !== want.filt)
            report($sformatf("filtered_load got %0d expected %0d", got.filt, want.filt));
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the block fills up and drops s_tready.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset settings: field extremes, a climb toward
    // the maximum, a fall toward the minimum, each battery bias band and low loads.
    put(7'd0, 24'd0, 1'b0, 7'd0);
    put(7'd127, 24'hFFFFFF, 1'b1, 7'd127);
    repeat (4) put(7'd100, 24'd2000000, 1'b1, 7'd50);
    repeat (2) put(7'd100, 24'd3000000, 1'b0, 7'd20);
    repeat (6) put(7'd0, 24'd3000000, 1'b0, 7'd21);
    repeat (3) put(7'd3, 24'd1000000, 1'b0, 7'd51);
    repeat (2) put(7'd50, 24'd800000, 1'b0, 7'd100);
    repeat (3) put(7'd0, 24'd800000, 1'b1, 7'd0);
    put(7'd101, 24'd0, 1'b0, 7'd64);
    drain();

    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), 24'(plan[p][r]));
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      add_random(RUN_TICKS);
      if (p == 2) hold_req++;
      drain();
    end

    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report($sformatf("%0d tick(s) never answered", due_results.size()));
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ldg_pkg.sv
rtl/core/ldg_cfg.sv
rtl/core/ldg_core.sv
rtl/core/load_based_dvfs_step_governor.sv
verif/tb.sv
